>>> design/pbrt_pkg.sv
`default_nettype none
package pbrt_pkg;

  localparam int RULE_ENTRIES = 64;
  localparam int CNT_W        = $clog2(RULE_ENTRIES + 1);
  localparam int OUT_CNT_W    = 7;

  localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
  localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
  localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;

  typedef enum logic [1:0] {
    CODE_ICMP = 2'd0,
    CODE_TCP  = 2'd1,
    CODE_UDP  = 2'd2,
    CODE_NONE = 2'd3
  } proto_code_t;

  typedef enum logic [1:0] {
    CMD_CLASSIFY = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ACCEPT    = 3'd0,
    ST_DROP      = 3'd1,
    ST_ADDED     = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_PROTO_ERR = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [7:0]  ip_protocol;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_CNT_W-1:0]  rules_in_use;
  } out_item_t;

  // request token walking down the cell row
  typedef struct packed {
    logic        active;
    cmd_t        cmd;
    logic [31:0] ip;
    logic [15:0] port;
    proto_code_t code;
    logic        done;
  } token_t;

  function automatic proto_code_t proto_to_code(input logic [7:0] proto);
    proto_code_t c;
    case (proto)
      PROTO_NUM_ICMP: c = CODE_ICMP;
      PROTO_NUM_TCP:  c = CODE_TCP;
      PROTO_NUM_UDP:  c = CODE_UDP;
      default:        c = CODE_NONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/packet_blocklist_rule_table_top.sv
`default_nettype none
// channel   direction  payload     handshake
// in_       input      in_item_t   in_valid / in_stall
// out_      output     out_item_t  out_valid / out_stall
//
// one transaction at a time: a request token walks the row of rule cells,
// one cell per cycle; the result is held in the output register, and no new
// transaction is taken until the token has left the row.
// synchronous active-low reset clears all valid bits and the rule count.
// in_stall is high while a token is in flight or a result waits stalled;
// a waiting result is held in the output register until taken.
module packet_blocklist_rule_table_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pbrt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pbrt_pkg::out_item_t      out_data
);

  localparam int N  = pbrt_pkg::RULE_ENTRIES;
  localparam int CW = pbrt_pkg::CNT_W;
  localparam int OW = pbrt_pkg::OUT_CNT_W;

  pbrt_pkg::token_t    tok_w [0:N];
  pbrt_pkg::token_t    tok0_r;
  logic [N:0]          act_vec;
  logic                run_r, run_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  pbrt_pkg::out_item_t out_r, out_nxt;
  logic                in_acc;
  pbrt_pkg::token_t    last;
  pbrt_pkg::status_t   st;

  assign tok_w[0] = tok0_r;
  assign last     = tok_w[N];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      pbrt_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .tok_i (tok_w[g]),
        .tok_o (tok_w[g+1])
      );
    end
    for (g = 0; g <= N; g++) begin : g_act
      assign act_vec[g] = tok_w[g].active;
    end
  endgenerate

  assign in_stall = run_r || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    st        = pbrt_pkg::ST_ACCEPT;
    count_nxt = count_r;
    case (last.cmd)
      pbrt_pkg::CMD_CLASSIFY: begin
        if (last.done) st = pbrt_pkg::ST_DROP;
      end
      pbrt_pkg::CMD_ADD: begin
        if (last.code == pbrt_pkg::CODE_NONE) begin
          st = pbrt_pkg::ST_PROTO_ERR;
        end else if (last.done) begin
          st        = pbrt_pkg::ST_ADDED;
          count_nxt = count_r + CW'(1);
        end else begin
          st = pbrt_pkg::ST_FULL;
        end
      end
      pbrt_pkg::CMD_DELETE: begin
        if (last.done) begin
          st        = pbrt_pkg::ST_DELETED;
          count_nxt = count_r - CW'(1);
        end else begin
          st = pbrt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    if (!last.active) count_nxt = count_r;

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    run_nxt       = run_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (in_acc) run_nxt = 1'b1;
    if (last.active) begin
      out_valid_nxt        = 1'b1;
      out_nxt.status       = st;
      out_nxt.rules_in_use = OW'(count_nxt);
      run_nxt              = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r         <= 1'b0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      tok0_r.active <= 1'b0;
    end else begin
      run_r         <= run_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      tok0_r.active <= in_acc;
    end
    out_r <= out_nxt;
    if (in_acc) begin
      tok0_r.cmd  <= pbrt_pkg::cmd_t'(in_data.command);
      tok0_r.ip   <= in_data.dest_ip;
      tok0_r.port <= in_data.dest_port;
      tok0_r.code <= pbrt_pkg::proto_to_code(in_data.ip_protocol);
      tok0_r.done <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(act_vec))
    else $error("more than one token in the cell row");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    last.active |-> !(out_valid_r && out_stall))
    else $error("result arrived while output register held a stalled result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("rule count above table size");

  a_out_from_token: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(last.active))
    else $error("result without a finished token");
`endif

endmodule
`default_nettype wire

>>> design/pbrt_cell.sv
`default_nettype none
module pbrt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbrt_pkg::token_t  tok_i,
  output pbrt_pkg::token_t       tok_o
);

  logic                  valid_r, valid_nxt;
  logic [31:0]           addr_r, addr_nxt;
  logic [15:0]           port_r, port_nxt;
  pbrt_pkg::proto_code_t code_r, code_nxt;
  pbrt_pkg::token_t      tok_r, tok_nxt;
  logic                  use_port;
  logic                  match;

  always_comb begin
    use_port = !(tok_i.cmd == pbrt_pkg::CMD_CLASSIFY && tok_i.code == pbrt_pkg::CODE_ICMP);
    match = valid_r && (addr_r == tok_i.ip) && (code_r == tok_i.code) &&
            (!use_port || (port_r == tok_i.port));
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    port_nxt  = port_r;
    code_nxt  = code_r;
    tok_nxt   = tok_i;
    if (tok_i.active && !tok_i.done) begin
      case (tok_i.cmd)
        pbrt_pkg::CMD_CLASSIFY: begin
          if (match) tok_nxt.done = 1'b1;
        end
        pbrt_pkg::CMD_ADD: begin
          if (!valid_r && tok_i.code != pbrt_pkg::CODE_NONE) begin
            valid_nxt     = 1'b1;
            addr_nxt      = tok_i.ip;
            port_nxt      = (tok_i.code == pbrt_pkg::CODE_ICMP) ? 16'd0 : tok_i.port;
            code_nxt      = tok_i.code;
            tok_nxt.done  = 1'b1;
          end
        end
        pbrt_pkg::CMD_DELETE: begin
          if (match) begin
            valid_nxt    = 1'b0;
            tok_nxt.done = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      tok_r.active <= tok_nxt.active;
    end
    addr_r     <= addr_nxt;
    port_r     <= port_nxt;
    code_r     <= code_nxt;
    tok_r.cmd  <= tok_nxt.cmd;
    tok_r.ip   <= tok_nxt.ip;
    tok_r.port <= tok_nxt.port;
    tok_r.code <= tok_nxt.code;
    tok_r.done <= tok_nxt.done;
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

>>> dv/packet_blocklist_rule_table_top_test.sv
`default_nettype none
module packet_blocklist_rule_table_top_test;
  import pbrt_pkg::*;

  localparam int RANDOM_ITEMS  = 1925;
  localparam int PHASE_LEN     = 150;
  localparam int DRAIN_EVERY   = 450;
  localparam int LONG_HOLD     = 400;
  localparam int LONG_HOLD_AT  = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = RULE_ENTRIES + 40;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pending_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  proto;
  } rule_key_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  pending_t  pending_q[$];
  out_item_t verdict_q[$];

  // shadow rule table
  bit          tbl_valid [RULE_ENTRIES];
  logic [31:0] tbl_addr  [RULE_ENTRIES];
  logic [15:0] tbl_port  [RULE_ENTRIES];
  proto_code_t tbl_code  [RULE_ENTRIES];
  int          rule_count = 0;

  logic [31:0] addr_set [8] = '{32'h0000_0000, 32'hffff_ffff, 32'h0a00_0001, 32'h0a00_0002,
                                32'hc0a8_0101, 32'hc0a8_01fe, 32'h7f00_0001, 32'h8000_0000};
  logic [15:0] port_set [4] = '{16'd0, 16'd80, 16'd443, 16'hffff};

  int mismatches  = 0;
  int accepted    = 0;
  int received    = 0;
  int send_wait   = 0;
  int recv_wait   = 0;
  int idle_cycles = 0;

  packet_blocklist_rule_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int draw_pause(int n);
    if (((n / 100) % 4) == 3) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic int lowest_rule_hit(logic [31:0] ip, logic [15:0] port, proto_code_t c,
                                         bit port_too);
    int i;
    for (i = 0; i < RULE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_addr[i] == ip && tbl_code[i] == c &&
          (!port_too || tbl_port[i] == port))
        return i;
    return -1;
  endfunction

  function automatic out_item_t predict_verdict(in_item_t t);
    proto_code_t c;
    int          slot;
    int          i;
    out_item_t   r;
    case (t.ip_protocol)
      PROTO_NUM_ICMP: c = CODE_ICMP;
      PROTO_NUM_TCP:  c = CODE_TCP;
      PROTO_NUM_UDP:  c = CODE_UDP;
      default:        c = CODE_NONE;
    endcase
    r.status = ST_ACCEPT;
    slot = -1;
    case (t.command)
      CMD_CLASSIFY: begin
        if (c != CODE_NONE && lowest_rule_hit(t.dest_ip, t.dest_port, c, c != CODE_ICMP) >= 0)
          r.status = ST_DROP;
      end
      CMD_ADD: begin
        if (c == CODE_NONE) begin
          r.status = ST_PROTO_ERR;
        end else begin
          for (i = 0; i < RULE_ENTRIES && slot < 0; i++)
            if (!tbl_valid[i]) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_addr[slot]  = t.dest_ip;
            tbl_port[slot]  = (c == CODE_ICMP) ? 16'd0 : t.dest_port;
            tbl_code[slot]  = c;
            rule_count++;
            r.status = ST_ADDED;
          end
        end
      end
      CMD_DELETE: begin
        if (c != CODE_NONE) slot = lowest_rule_hit(t.dest_ip, t.dest_port, c, 1'b1);
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          if (rule_count > 0) rule_count--;
          r.status = ST_DELETED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.rules_in_use = OUT_CNT_W'(rule_count);
    return r;
  endfunction

  function automatic in_item_t mk(cmd_t cmd, logic [31:0] ip, logic [15:0] port,
                                  logic [7:0] proto);
    in_item_t t;
    t.command     = cmd;
    t.dest_ip     = ip;
    t.dest_port   = port;
    t.ip_protocol = proto;
    return t;
  endfunction

  function automatic rule_key_t rand_key();
    rule_key_t k;
    k.ip   = ($urandom_range(0, 7) == 0) ? $urandom : addr_set[$urandom_range(0, 7)];
    k.port = ($urandom_range(0, 3) == 0) ? 16'($urandom) : port_set[$urandom_range(0, 3)];
    case ($urandom_range(0, 9))
      0, 1, 2: k.proto = PROTO_NUM_TCP;
      3, 4, 5: k.proto = PROTO_NUM_UDP;
      6, 7, 8: k.proto = PROTO_NUM_ICMP;
      default: k.proto = 8'($urandom);
    endcase
    return k;
  endfunction

  task automatic push_item(in_item_t t, bit drain_first);
    pending_t p;
    p.item        = t;
    p.drain_first = drain_first;
    pending_q.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      send_wait <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back(predict_verdict(in_data));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          in_valid  <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_q.size() > 0 &&
                     (!pending_q[0].drain_first || verdict_q.size() == 0)) begin
          in_valid  <= 1'b1;
          in_data   <= pending_q[0].item;
          send_wait <= draw_pause(accepted);
          pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        received++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected transaction %0d: status %0d rules %0d",
                     received, out_data.status, out_data.rules_in_use);
        end else begin
          want = verdict_q.pop_front();
          if (out_data.status !== want.status || out_data.rules_in_use !== want.rules_in_use) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("transaction %0d: expected status %0d rules %0d, got status %0d rules %0d",
                       received, want.status, want.rules_in_use,
                       out_data.status, out_data.rules_in_use);
          end
        end
        recv_wait = (received == LONG_HOLD_AT) ? LONG_HOLD : draw_pause(received);
      end
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rule_key_t pool[$];
    rule_key_t k;
    in_item_t  t;
    int        n;
    int        pick;
    int        idx;
    int        add_pct;
    int        del_pct;

    // directed
    push_item(mk(CMD_CLASSIFY, 32'h0a00_0001, 16'd80, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_ADD, 32'h0a00_0001, 16'd80, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'h0a00_0001, 16'd80, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'h0a00_0001, 16'd81, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'h0a00_0001, 16'd80, PROTO_NUM_UDP), 1'b0);
    push_item(mk(CMD_ADD, 32'hffff_ffff, 16'hffff, PROTO_NUM_UDP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'hffff_ffff, 16'hffff, PROTO_NUM_UDP), 1'b0);
    push_item(mk(CMD_ADD, 32'h0000_0000, 16'd1234, PROTO_NUM_ICMP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'h0000_0000, 16'd5555, PROTO_NUM_ICMP), 1'b0);
    push_item(mk(CMD_DELETE, 32'h0000_0000, 16'd1234, PROTO_NUM_ICMP), 1'b0);
    push_item(mk(CMD_DELETE, 32'h0000_0000, 16'd0, PROTO_NUM_ICMP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'h0000_0000, 16'd0, PROTO_NUM_ICMP), 1'b0);
    push_item(mk(CMD_ADD, 32'h0a00_0002, 16'd22, 8'd0), 1'b0);
    push_item(mk(CMD_ADD, 32'h0a00_0002, 16'd22, 8'hff), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'h0a00_0001, 16'd80, 8'hff), 1'b0);
    push_item(mk(CMD_DELETE, 32'h0a00_0001, 16'd80, 8'd47), 1'b0);
    push_item(mk(CMD_ADD, 32'h0a00_0001, 16'd80, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_DELETE, 32'h0a00_0001, 16'd80, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'h0a00_0001, 16'd80, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_DELETE, 32'h0a00_0001, 16'd80, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_DELETE, 32'h0a00_0001, 16'd80, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_NOP, 32'hffff_ffff, 16'hffff, 8'hff), 1'b0);
    push_item(mk(CMD_ADD, 32'h0000_0000, 16'd0, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'h0000_0000, 16'd0, PROTO_NUM_TCP), 1'b0);
    push_item(mk(CMD_CLASSIFY, 32'hffff_ffff, 16'h0000, PROTO_NUM_UDP), 1'b1);

    // random: fill, mixed and drain phases
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / PHASE_LEN) % 3)
        0:       begin add_pct = 75; del_pct = 10; end
        1:       begin add_pct = 35; del_pct = 30; end
        default: begin add_pct = 15; del_pct = 55; end
      endcase
      if ($urandom_range(0, 99) < 8) begin
        t.command     = 2'($urandom);
        t.dest_ip     = $urandom;
        t.dest_port   = 16'($urandom);
        t.ip_protocol = $urandom_range(0, 1) ? 8'($urandom) : rand_key().proto;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
          k = rand_key();
          pool.push_back(k);
          t = mk(CMD_ADD, k.ip, k.port, k.proto);
        end else if (pick < add_pct + del_pct) begin
          if (pool.size() > 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, pool.size() - 1);
            k = pool[idx];
            pool.delete(idx);
            if (k.proto == PROTO_NUM_ICMP && $urandom_range(0, 4) != 0) k.port = '0;
          end else begin
            k = rand_key();
          end
          t = mk(CMD_DELETE, k.ip, k.port, k.proto);
        end else begin
          if (pool.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, pool.size() - 1);
            k = pool[idx];
            if ($urandom_range(0, 3) == 0) k.port = k.port + 16'd1;
          end else begin
            k = rand_key();
          end
          t = mk(CMD_CLASSIFY, k.ip, k.port, k.proto);
        end
      end
      push_item(t, (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
